### src/ois_pkg.sv
package ois_pkg;

    localparam int UNIVERSE_BITS = 12;
    localparam int WORD_BITS = 64;

    localparam int KEY_W = 14;
    localparam int CMD_W = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SUCC = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PRED = 3'd4;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_WORD  = 6'b000100,
        ST_NEIGH = 6'b001000,
        ST_MARKS = 6'b010000,
        ST_SPARE = 6'b100000
    } t_state;

    typedef struct packed {
        logic clr;
        logic ld_item;
        logic upd;
        logic nb;
        logic ld_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } t_sts;

endpackage

### src/ordered_integer_set.sv
// channel  direction  handshake          payload
// in       input      i_valid / o_stall  i_command, i_key
// out      output     o_valid / i_stall  o_ok, o_answer, o_set_min, o_set_max, o_is_empty
//
// each item steps from transfer to result register: word read at the transfer,
// update and neighbor read, mark reads on two memory ports, result load; the next item
// is taken the cycle after the result is loaded, not before the last item is through
// after reset a clearing pass writes zero over all 2^(UNIVERSE_BITS - log2 WORD_BITS)
// memory words, one a cycle (64 words at the defaults), with o_stall high
// a stalled result holds; the block waits with a new result until the old one is taken
module ordered_integer_set (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [ois_pkg::CMD_W-1:0]           i_command,
    input  logic signed [ois_pkg::KEY_W-1:0]    i_key,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_ok,
    output logic [ois_pkg::UNIVERSE_BITS-1:0]   o_answer,
    output logic [ois_pkg::UNIVERSE_BITS-1:0]   o_set_min,
    output logic [ois_pkg::UNIVERSE_BITS-1:0]   o_set_max,
    output logic                                o_is_empty
);

    ois_pkg::t_cmd cmd;
    ois_pkg::t_sts sts;

    ois_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ois_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_command  (i_command),
        .i_key      (i_key),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_ok       (o_ok),
        .o_answer   (o_answer),
        .o_set_min  (o_set_min),
        .o_set_max  (o_set_max),
        .o_is_empty (o_is_empty)
    );

endmodule

### src/ois_ctrl.sv
module ois_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ois_pkg::t_sts i_sts,
    output ois_pkg::t_cmd o_cmd
);

    ois_pkg::t_state r_state;
    ois_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_stall = 1'b1;
        case (r_state)
            ois_pkg::ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = ois_pkg::ST_IDLE;
            end
            ois_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.ld_item = 1'b1;
                    n_state = ois_pkg::ST_WORD;
                end
            end
            ois_pkg::ST_WORD: begin
                o_cmd.upd = 1'b1;
                n_state = ois_pkg::ST_NEIGH;
            end
            ois_pkg::ST_NEIGH: begin
                o_cmd.nb = 1'b1;
                n_state = ois_pkg::ST_MARKS;
            end
            ois_pkg::ST_MARKS: begin
                if (!i_sts.out_busy) begin
                    o_cmd.ld_out = 1'b1;
                    n_state = ois_pkg::ST_IDLE;
                end
            end
            default: n_state = ois_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ois_pkg::ST_CLEAR;
        else r_state <= n_state;
    end

endmodule

### src/ois_dp.sv
module ois_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ois_pkg::t_cmd                       i_cmd,
    output ois_pkg::t_sts                       o_sts,
    input  logic [ois_pkg::CMD_W-1:0]           i_command,
    input  logic signed [ois_pkg::KEY_W-1:0]    i_key,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic                                o_ok,
    output logic [ois_pkg::UNIVERSE_BITS-1:0]   o_answer,
    output logic [ois_pkg::UNIVERSE_BITS-1:0]   o_set_min,
    output logic [ois_pkg::UNIVERSE_BITS-1:0]   o_set_max,
    output logic                                o_is_empty
);

    localparam int WORD_BITS = ois_pkg::WORD_BITS;
    localparam int UB = ois_pkg::UNIVERSE_BITS;
    localparam int VW = UB + 1;
    localparam int WBL = $clog2(WORD_BITS);
    localparam int WIW = UB - WBL;
    localparam int WC = 1 << WIW;
    localparam int USIZE = 1 << UB;

    function automatic logic [WBL-1:0] lo_w(input logic [WORD_BITS-1:0] x);
        logic [WBL-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) if (x[i]) r = WBL'(i);
        return r;
    endfunction

    function automatic logic [WBL-1:0] hi_w(input logic [WORD_BITS-1:0] x);
        logic [WBL-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_BITS; i++) if (x[i]) r = WBL'(i);
        return r;
    endfunction

    function automatic logic [WIW-1:0] lo_s(input logic [WC-1:0] x);
        logic [WIW-1:0] r;
        r = '0;
        for (int i = WC - 1; i >= 0; i--) if (x[i]) r = WIW'(i);
        return r;
    endfunction

    function automatic logic [WIW-1:0] hi_s(input logic [WC-1:0] x);
        logic [WIW-1:0] r;
        r = '0;
        for (int i = 0; i < WC; i++) if (x[i]) r = WIW'(i);
        return r;
    endfunction

    logic [WORD_BITS-1:0] r_mem [WC];
    logic [WORD_BITS-1:0] r_rda;
    logic [WORD_BITS-1:0] r_rdb;
    logic [WC-1:0]        r_sum;
    logic [WIW-1:0]       r_clr;
    logic [ois_pkg::CMD_W-1:0] r_cmd;
    logic [VW-1:0]        r_val;
    logic                 r_rng;
    logic                 r_pend;
    logic [WIW-1:0]       r_g;
    logic [WIW-1:0]       r_lo_g;
    logic [WIW-1:0]       r_hi_g;
    logic                 r_ok;
    logic [UB-1:0]        r_ans;
    logic                 r_valid;
    logic                 r_o_ok;
    logic [UB-1:0]        r_o_ans;
    logic [UB-1:0]        r_o_min;
    logic [UB-1:0]        r_o_max;
    logic                 r_o_empty;

    int                   ks;
    logic [VW-1:0]        n_val;
    logic                 n_rng;
    logic [WIW-1:0]       idx;
    logic [WIW:0]         widx;
    logic [WBL-1:0]       bpos;
    logic [WORD_BITS-1:0] bmask;
    logic [WORD_BITS-1:0] up_m;
    logic [WORD_BITS-1:0] dn_m;
    logic [WC-1:0]        s_up;
    logic [WC-1:0]        s_dn;
    logic                 mbit;
    logic                 u_ok;
    logic [UB-1:0]        u_ans;
    logic                 u_pend;
    logic [WIW-1:0]       u_g;
    logic                 u_we;
    logic [WORD_BITS-1:0] u_wd;
    logic [WC-1:0]        u_sum;
    logic                 rd_a_en;
    logic [WIW-1:0]       rd_a_addr;
    logic                 we;
    logic [WIW-1:0]       wa;
    logic [WORD_BITS-1:0] wd;

    always_comb begin
        ks = int'(i_key);
        n_val = (i_command == ois_pkg::CMD_SUCC) ? VW'(ks + 1) : VW'(ks);
        case (i_command)
            ois_pkg::CMD_INSERT, ois_pkg::CMD_REMOVE, ois_pkg::CMD_CONTAINS:
                n_rng = (ks >= 0) && (ks < USIZE);
            ois_pkg::CMD_SUCC: n_rng = (ks >= -1) && (ks < USIZE - 1);
            ois_pkg::CMD_PRED: n_rng = (ks >= 1) && (ks <= USIZE);
            default: n_rng = 1'b0;
        endcase
    end

    always_comb begin
        idx = r_val[UB-1:WBL];
        widx = r_val[UB:WBL];
        bpos = r_val[WBL-1:0];
        bmask = '0;
        bmask[bpos] = 1'b1;
        mbit = r_rda[bpos];
        for (int i = 0; i < WORD_BITS; i++) begin
            up_m[i] = r_rda[i] && (i >= int'(bpos));
            dn_m[i] = r_rda[i] && (i < int'(bpos));
        end
        for (int i = 0; i < WC; i++) begin
            s_up[i] = r_sum[i] && (i > int'(idx));
            s_dn[i] = r_sum[i] && (i < int'(widx));
        end
        u_ok = 1'b0;
        u_ans = '0;
        u_pend = 1'b0;
        u_g = '0;
        u_we = 1'b0;
        u_wd = r_rda;
        u_sum = r_sum;
        case (r_cmd)
            ois_pkg::CMD_INSERT: begin
                u_ok = r_rng && !mbit;
                u_we = u_ok;
                u_wd = r_rda | bmask;
                if (u_ok) u_sum[idx] = 1'b1;
            end
            ois_pkg::CMD_REMOVE: begin
                u_ok = r_rng && mbit;
                u_we = u_ok;
                u_wd = r_rda & ~bmask;
                if (u_ok && u_wd == '0) u_sum[idx] = 1'b0;
            end
            ois_pkg::CMD_CONTAINS: u_ok = r_rng && mbit;
            ois_pkg::CMD_SUCC: begin
                if (r_rng && up_m != '0) begin
                    u_ok = 1'b1;
                    u_ans = {idx, lo_w(up_m)};
                end else if (r_rng && s_up != '0) begin
                    u_pend = 1'b1;
                    u_g = lo_s(s_up);
                end
            end
            ois_pkg::CMD_PRED: begin
                if (r_rng && bpos != '0 && dn_m != '0) begin
                    u_ok = 1'b1;
                    u_ans = {idx, hi_w(dn_m)};
                end else if (r_rng && s_dn != '0) begin
                    u_pend = 1'b1;
                    u_g = hi_s(s_dn);
                end
            end
            default: u_ok = 1'b0;
        endcase
    end

    always_comb begin
        rd_a_en = 1'b0;
        rd_a_addr = '0;
        if (i_cmd.ld_item) begin
            rd_a_en = 1'b1;
            rd_a_addr = n_val[UB-1:WBL];
        end else if (i_cmd.upd) begin
            rd_a_en = 1'b1;
            rd_a_addr = u_g;
        end else if (i_cmd.nb) begin
            rd_a_en = 1'b1;
            rd_a_addr = lo_s(r_sum);
        end
        we = i_cmd.clr || (i_cmd.upd && u_we);
        wa = i_cmd.clr ? r_clr : idx;
        wd = i_cmd.clr ? '0 : u_wd;
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (rd_a_en) r_rda <= r_mem[rd_a_addr];
        if (i_cmd.nb) r_rdb <= r_mem[hi_s(r_sum)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_clr <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.upd) r_sum <= u_sum;
            if (i_cmd.ld_out) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_cmd <= i_command;
            r_val <= n_val;
            r_rng <= n_rng;
        end
        if (i_cmd.upd) begin
            r_ok <= u_ok;
            r_ans <= u_ans;
            r_pend <= u_pend;
            r_g <= u_g;
        end
        if (i_cmd.nb) begin
            r_lo_g <= lo_s(r_sum);
            r_hi_g <= hi_s(r_sum);
            if (r_pend) begin
                r_ok <= 1'b1;
                r_ans <= (r_cmd == ois_pkg::CMD_SUCC) ? {r_g, lo_w(r_rda)} : {r_g, hi_w(r_rda)};
            end
        end
        if (i_cmd.ld_out) begin
            r_o_ok <= r_ok;
            r_o_ans <= r_ans;
            r_o_empty <= (r_sum == '0);
            r_o_min <= (r_sum == '0) ? '0 : {r_lo_g, lo_w(r_rda)};
            r_o_max <= (r_sum == '0) ? '0 : {r_hi_g, hi_w(r_rdb)};
        end
    end

    assign o_sts.clr_last = (r_clr == WIW'(WC - 1));
    assign o_sts.out_busy = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_ok = r_o_ok;
    assign o_answer = r_o_ans;
    assign o_set_min = r_o_min;
    assign o_set_max = r_o_max;
    assign o_is_empty = r_o_empty;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int UNIV_BITS = ois_pkg::UNIVERSE_BITS;
    localparam int UNIV = 1 << UNIV_BITS;
    localparam int IDLE_MAX = 13;
    localparam int QUIET_LIMIT = 2000;

    typedef logic [ois_pkg::CMD_W-1:0] t_cmd_code;
    typedef logic signed [ois_pkg::KEY_W-1:0] t_key;

    typedef struct packed {
        logic                  ok;
        logic [UNIV_BITS-1:0]  answer;
        logic [UNIV_BITS-1:0]  set_min;
        logic [UNIV_BITS-1:0]  set_max;
        logic                  is_empty;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_cmd_code             i_command = ois_pkg::CMD_INSERT;
    t_key                  i_key = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b1;
    logic                  o_ok;
    logic [UNIV_BITS-1:0]  o_answer;
    logic [UNIV_BITS-1:0]  o_set_min;
    logic [UNIV_BITS-1:0]  o_set_max;
    logic                  o_is_empty;

    bit      members [UNIV];
    t_result expected_results [$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    bit      hold_output = 1'b0;
    bit      timed_out = 1'b0;

    ordered_integer_set DUT (.*);

    always #2 i_clk = ~i_clk;

    function automatic t_result predict_set_op(t_cmd_code cmd, t_key k);
        t_result r;
        int key;
        int v;
        bit in_range;
        r = '0;
        key = int'(k);
        in_range = key >= 0 && key < UNIV;
        case (cmd)
            ois_pkg::CMD_INSERT: begin
                if (in_range && !members[key]) begin
                    members[key] = 1'b1;
                    r.ok = 1'b1;
                end
            end
            ois_pkg::CMD_REMOVE: begin
                if (in_range && members[key]) begin
                    members[key] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            ois_pkg::CMD_CONTAINS: r.ok = in_range && members[key];
            ois_pkg::CMD_SUCC: begin
                if (key >= -1 && key < UNIV) begin
                    for (v = key + 1; v < UNIV; v++) begin
                        if (members[v]) begin
                            r.ok = 1'b1;
                            r.answer = v[UNIV_BITS-1:0];
                            break;
                        end
                    end
                end
            end
            ois_pkg::CMD_PRED: begin
                if (key >= 0 && key <= UNIV) begin
                    for (v = key - 1; v >= 0; v--) begin
                        if (members[v]) begin
                            r.ok = 1'b1;
                            r.answer = v[UNIV_BITS-1:0];
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.is_empty = 1'b1;
        for (v = 0; v < UNIV; v++) begin
            if (members[v]) begin
                if (r.is_empty) r.set_min = v[UNIV_BITS-1:0];
                r.set_max = v[UNIV_BITS-1:0];
                r.is_empty = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic send_item(t_cmd_code cmd, int key);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_key <= key[ois_pkg::KEY_W-1:0];
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(predict_set_op(cmd, key[ois_pkg::KEY_W-1:0]));
    endtask

    // receiver side: random stall per result, or a long hold when asked
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_output) begin
                i_stall <= 1'b1;
                @(posedge i_clk);
            end else begin
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, IDLE_MAX);
                i_stall <= gap != 0;
                repeat (gap) @(posedge i_clk);
                if (gap != 0) i_stall <= 1'b0;
                do @(posedge i_clk); while (!(o_valid && !i_stall) && !hold_output);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (o_valid && !i_stall && i_rst_n) begin
            got = '{o_ok, o_answer, o_set_min, o_set_max, o_is_empty};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch expected %p actual %p", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || hold_output) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            timed_out = 1'b1;
        end
    end

    task automatic test_directed();
        int k;
        send_item(ois_pkg::CMD_PRED, UNIV);
        send_item(ois_pkg::CMD_SUCC, -1);
        send_item(ois_pkg::CMD_REMOVE, 5);
        send_item(ois_pkg::CMD_INSERT, 0);
        send_item(ois_pkg::CMD_INSERT, UNIV - 1);
        send_item(ois_pkg::CMD_INSERT, 0);
        send_item(ois_pkg::CMD_INSERT, UNIV);
        send_item(ois_pkg::CMD_INSERT, -1);
        send_item(ois_pkg::CMD_INSERT, 8191);
        send_item(ois_pkg::CMD_INSERT, -8192);
        send_item(ois_pkg::CMD_INSERT, 64);
        send_item(ois_pkg::CMD_CONTAINS, 64);
        send_item(ois_pkg::CMD_CONTAINS, -5);
        send_item(ois_pkg::CMD_SUCC, -1);
        send_item(ois_pkg::CMD_SUCC, 0);
        send_item(ois_pkg::CMD_SUCC, UNIV - 1);
        send_item(ois_pkg::CMD_SUCC, -2);
        send_item(ois_pkg::CMD_PRED, UNIV);
        send_item(ois_pkg::CMD_PRED, 0);
        send_item(ois_pkg::CMD_PRED, UNIV + 1);
        for (k = 5; k < 8; k++) send_item(k[ois_pkg::CMD_W-1:0], 100);
        send_item(ois_pkg::CMD_REMOVE, 0);
        send_item(ois_pkg::CMD_REMOVE, 64);
        send_item(ois_pkg::CMD_REMOVE, UNIV - 1);
        send_item(ois_pkg::CMD_SUCC, -1);
    endtask

    function automatic int pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3) return $urandom_range(0, 16383) - 8192;
        if (sel < 8) return $urandom_range(0, 1) ? -1 : UNIV;
        if (sel < 40) return $urandom_range(0, 255) * 16;
        if (sel < 55) return 1024 + $urandom_range(0, 191);
        return $urandom_range(0, UNIV - 1);
    endfunction

    task automatic test_random(int count);
        int n;
        int sel;
        t_cmd_code cmd;
        for (n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) cmd = ois_pkg::CMD_INSERT;
            else if (sel < 55) cmd = ois_pkg::CMD_REMOVE;
            else if (sel < 68) cmd = ois_pkg::CMD_CONTAINS;
            else if (sel < 82) cmd = ois_pkg::CMD_SUCC;
            else if (sel < 97) cmd = ois_pkg::CMD_PRED;
            else cmd = t_cmd_code'($urandom_range(5, 7));
            send_item(cmd, pick_key());
        end
    endtask

    task automatic test_drain_to_empty();
        int v;
        for (v = 0; v < UNIV; v++) begin
            if (members[v]) send_item(ois_pkg::CMD_REMOVE, v);
        end
        send_item(ois_pkg::CMD_SUCC, -1);
        send_item(ois_pkg::CMD_PRED, UNIV);
    endtask

    task automatic test_backpressure();
        int n;
        hold_output = 1'b1;
        fork
            for (n = 0; n < 12; n++) send_item(ois_pkg::CMD_INSERT, $urandom_range(0, UNIV - 1));
            begin
                repeat (120) @(posedge i_clk);
                hold_output = 1'b0;
            end
        join
    endtask

    initial begin
        fork
            begin
                repeat (6) @(posedge i_clk);
                i_rst_n <= 1'b1;
                @(posedge i_clk);
                test_directed();
                test_random(900);
                test_backpressure();
                test_drain_to_empty();
                test_random(900);
                i_valid <= 1'b0;
                wait (expected_results.size() == 0);
                repeat (20) @(posedge i_clk);
            end
            wait (timed_out);
        join_any
        if (!timed_out && mismatches == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
